>>> rtl/core/vug_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vug_pkg;

  localparam int HIST_DEPTH = 32;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int TAG_W      = 16;
  localparam int CFG_W      = 6;

  localparam logic [CFG_W-1:0] HANG_RESET = CFG_W'(8);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_DATA   = 2'd1,
    OP_FINISH = 2'd2
  } cmd_t;

  typedef struct packed {
    logic             voice_active;
    logic [TAG_W-1:0] frame_tag;
  } vug_in_t;

  typedef struct packed {
    cmd_t             command;
    logic             final_frame;
    logic [TAG_W-1:0] out_tag;
    logic             last;
  } vug_out_t;

  typedef struct packed {
    logic             advance;
    logic             rotate;
    logic [TAG_W-1:0] head_tag;
  } chain_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/vug_tag_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module vug_tag_cell
  import vug_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [TAG_W-1:0] d,
  output logic      [TAG_W-1:0] q
);

  logic [TAG_W-1:0] tag_r;

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r <= d;
    end
  end

  assign q = tag_r;

endmodule

`default_nettype wire

>>> rtl/core/vug_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module vug_ctrl
  import vug_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire vug_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output vug_out_t              out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire logic [TAG_W-1:0] tail_tag,
  output chain_ctl_t            chain_ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ROT,
    S_DATA,
    S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic               prev_voice_r, prev_voice_nxt;
  logic               in_utt_r, in_utt_nxt;
  logic [CNT_W-1:0]   sc_r, sc_nxt;
  logic [CFG_W-1:0]   hang_r, hang_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               fin_r, fin_nxt;
  logic [HIST_AW-1:0] rot_idx_r, rot_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  vug_out_t           out_data_r, out_data_nxt;

  logic             accept;
  logic             out_free;
  logic [CNT_W-1:0] thr;
  logic [CNT_W-1:0] sc_inc;
  logic [CNT_W:0]   rot_sum;
  logic             rot_emit;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    thr = CNT_W'(hang_r);
    if (thr == '0) begin
      thr = CNT_W'(1);
    end
    if (thr > CNT_W'(HIST_DEPTH)) begin
      thr = CNT_W'(HIST_DEPTH);
    end
    sc_inc   = (sc_r < thr) ? sc_r + CNT_W'(1) : sc_r;
    rot_sum  = (CNT_W+1)'(rot_idx_r) + (CNT_W+1)'(cnt_r);
    rot_emit = (rot_sum >= (CNT_W+1)'(HIST_DEPTH));
  end

  always_comb begin
    state_nxt      = state_r;
    prev_voice_nxt = prev_voice_r;
    in_utt_nxt     = in_utt_r;
    sc_nxt         = sc_r;
    hang_nxt       = cfg_wr_en ? cfg_wr_data : hang_r;
    tag_nxt        = tag_r;
    cnt_nxt        = cnt_r;
    fin_nxt        = fin_r;
    rot_idx_nxt    = rot_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    chain_ctl      = '{advance: 1'b0, rotate: 1'b0, head_tag: tag_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tag_nxt     = in_data.frame_tag;
          fin_nxt     = 1'b0;
          cnt_nxt     = '0;
          rot_idx_nxt = '0;
          state_nxt   = S_DATA;
          if (!prev_voice_r && !in_data.voice_active) begin
            sc_nxt = sc_inc;
            if (in_utt_r) begin
              if (sc_inc >= thr) begin
                fin_nxt    = 1'b1;
                in_utt_nxt = 1'b0;
              end
            end else begin
              state_nxt = S_IDLE;
            end
          end else if (!prev_voice_r) begin
            if (!in_utt_r) begin
              in_utt_nxt = 1'b1;
              cnt_nxt    = (sc_r < thr) ? sc_r : thr;
              state_nxt  = S_START;
            end else if (sc_r >= thr) begin
              state_nxt = S_IDLE;
            end
            sc_nxt         = '0;
            prev_voice_nxt = 1'b1;
          end else if (!in_data.voice_active) begin
            sc_nxt         = CNT_W'(1);
            prev_voice_nxt = 1'b0;
          end else begin
            sc_nxt = '0;
          end
          if (state_nxt == S_IDLE) begin
            chain_ctl = '{advance: 1'b1, rotate: 1'b0, head_tag: in_data.frame_tag};
          end
        end
      end
      S_START: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{command: OP_START, final_frame: 1'b0, out_tag: '0, last: 1'b0};
          state_nxt     = S_ROT;
        end
      end
      S_ROT: begin
        if (!rot_emit || out_free) begin
          chain_ctl   = '{advance: 1'b1, rotate: 1'b1, head_tag: tag_r};
          rot_idx_nxt = rot_idx_r + HIST_AW'(1);
          if (rot_emit) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{command: OP_DATA, final_frame: 1'b0, out_tag: tail_tag,
                              last: 1'b0};
          end
          if (rot_idx_r == HIST_AW'(HIST_DEPTH - 1)) begin
            state_nxt = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (out_free) begin
          chain_ctl     = '{advance: 1'b1, rotate: 1'b0, head_tag: tag_r};
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{command: OP_DATA, final_frame: fin_r, out_tag: tag_r,
                            last: !fin_r};
          state_nxt     = fin_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{command: OP_FINISH, final_frame: 1'b0, out_tag: '0, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prev_voice_r <= 1'b0;
      in_utt_r     <= 1'b0;
      sc_r         <= '0;
      hang_r       <= HANG_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_voice_r <= prev_voice_nxt;
      in_utt_r     <= in_utt_nxt;
      sc_r         <= sc_nxt;
      hang_r       <= hang_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    tag_r      <= tag_nxt;
    cnt_r      <= cnt_nxt;
    fin_r      <= fin_nxt;
    rot_idx_r  <= rot_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_idle_no_voice: assert property (@(posedge clk) disable iff (!rst_n)
    !in_utt_r |-> !prev_voice_r)
    else $error("voice flag set outside an utterance");

  a_voice_clears_silence: assert property (@(posedge clk) disable iff (!rst_n)
    prev_voice_r |-> (sc_r == '0))
    else $error("silence count not cleared during voice");

  a_silence_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sc_r <= CNT_W'(HIST_DEPTH))
    else $error("silence count beyond history depth");

  a_rot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT && rot_emit && out_valid_r && out_stall) |=> $stable(rot_idx_r))
    else $error("history rotated while a replayed transaction was blocked");

  a_final_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.final_frame) |->
      (out_data_r.command == OP_DATA && !out_data_r.last))
    else $error("final flag on a transaction that is not a closing data frame");
`endif

endmodule

`default_nettype wire

>>> rtl/core/vug_utterance_gate_top_placeholder.sv
`timescale 1ns / 1ps
`default_nettype none

module vug_tag_row
  import vug_pkg::*;
(
  input  wire logic             clk,
  input  wire chain_ctl_t       chain_ctl,
  output logic      [TAG_W-1:0] tail_tag
);

  logic [TAG_W-1:0] cell_d [HIST_DEPTH];
  logic [TAG_W-1:0] cell_q [HIST_DEPTH];

  always_comb begin
    cell_d[0] = chain_ctl.rotate ? cell_q[HIST_DEPTH-1] : chain_ctl.head_tag;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      cell_d[i] = cell_q[i-1];
    end
  end

  for (genvar g = 0; g < HIST_DEPTH; g++) begin : g_cell
    vug_tag_cell u_cell (
      .clk (clk),
      .en  (chain_ctl.advance),
      .d   (cell_d[g]),
      .q   (cell_q[g])
    );
  end

  assign tail_tag = cell_q[HIST_DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/core/vad_utterance_gate.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    vug_in_t  (voice_active, frame_tag)
// out_      output     out_valid / out_stall  vug_out_t (command, final_frame, out_tag, last)
// cfg_      input      cfg_wr_en              cfg_wr_data (hangover_frames)
//
// One input transaction is taken at a time. A frame that starts an utterance passes
// through the start, 32 rotation steps of the tag history chain and the current frame
// before the next is taken; a frame with no result goes straight back to idle, a data
// frame passes through the data state and a closing data frame also through finish.
// The 32-cell history chain turns once round at the onset of an utterance.
// Reset is synchronous and active low; the history cells are not cleared.
// A stalled result register holds the sequencer; input is stalled until it is idle.
`timescale 1ns / 1ps
`default_nettype none

module vad_utterance_gate
  import vug_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire vug_in_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output vug_out_t              out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  chain_ctl_t       chain_ctl;
  logic [TAG_W-1:0] tail_tag;

  vug_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tail_tag    (tail_tag),
    .chain_ctl   (chain_ctl)
  );

  vug_tag_row u_row (
    .clk       (clk),
    .chain_ctl (chain_ctl),
    .tail_tag  (tail_tag)
  );

endmodule

`default_nettype wire
